@@ hdl/qcd_pkg.sv @@
// Shared types, constants and digit helpers for the quadrature counter display.
package qcd_pkg;

    localparam int unsigned QualWidth   = 8;
    localparam int unsigned ChangeWidth = 4;
    localparam int unsigned MuxWidth    = 8;
    localparam int unsigned CountWidth  = 8;
    localparam int unsigned SegWidth    = 7;
    localparam int unsigned EnWidth     = 2;
    localparam int unsigned MagWidth    = 7;
    localparam int unsigned DigitWidth  = 4;

    localparam logic signed [CountWidth-1:0] CountMax = 8'sd99;
    localparam logic signed [CountWidth-1:0] CountMin = -8'sd99;

    localparam logic [QualWidth-1:0]   QualifyReset = 8'd16;
    localparam logic [ChangeWidth-1:0] ChangeReset  = 4'd4;
    localparam logic [MuxWidth-1:0]    MuxReset     = 8'd16;

    localparam logic [1:0] PinsIdle = 2'b11;
    localparam logic [SegWidth-1:0] SegBlank = 7'h7F;

    // Register indexes on the configuration port
    localparam logic [1:0] RegQualifyCount   = 2'd0;
    localparam logic [1:0] RegChangesPerStep = 2'd1;
    localparam logic [1:0] RegMuxPeriod      = 2'd2;

    // Digit enable codes
    localparam logic [EnWidth-1:0] EnNone  = 2'd0;
    localparam logic [EnWidth-1:0] EnUnits = 2'd1;
    localparam logic [EnWidth-1:0] EnTens  = 2'd2;

    typedef struct packed {
        logic [QualWidth-1:0]   qualify_count;
        logic [ChangeWidth-1:0] changes_per_step;
        logic [MuxWidth-1:0]    mux_period;
    } cfg_t;

    // Active-high font, bit0 segment a .. bit6 segment g
    localparam logic [SegWidth-1:0] DigitFont [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
    };

    // Tens digit of a value below 100: multiply by 205/2048
    function automatic logic [DigitWidth-1:0] tens_of(input logic [MagWidth-1:0] mag);
        logic [MagWidth+8-1:0] prod;
        prod = {8'd0, mag} * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [DigitWidth-1:0] units_of(input logic [MagWidth-1:0] mag);
        logic [DigitWidth-1:0] tens;
        logic [MagWidth-1:0]   tens_x10;
        tens     = tens_of(mag);
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        return DigitWidth'(mag - tens_x10);
    endfunction

endpackage

@@ hdl/qcd_encoder.sv @@
// Debounce qualifier, change divider and saturating up/down counter.
module qcd_encoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  logic [1:0]                            sample,
    input  qcd_pkg::cfg_t                         cfg,
    output logic signed [qcd_pkg::CountWidth-1:0] count_next,
    output logic signed [qcd_pkg::CountWidth-1:0] count_reg
);

    logic [1:0]                       pins_reg, pins_next;
    logic [qcd_pkg::QualWidth-1:0]    qual_reg, qual_next;
    logic [qcd_pkg::ChangeWidth-1:0]  change_reg, change_next;
    logic [qcd_pkg::ChangeWidth-1:0]  change_inc;
    logic                             count_up;

    always_comb
    begin
        pins_next   = pins_reg;
        qual_next   = qual_reg;
        change_next = change_reg;
        count_next  = count_reg;
        change_inc  = change_reg + 1'b1;
        count_up    = (sample[0] == pins_reg[1]);
        if (sample != pins_reg)
        begin
            if (qual_reg == cfg.qualify_count)
            begin
                pins_next = sample;
                qual_next = '0;
                if (change_inc == cfg.changes_per_step)
                begin
                    change_next = '0;
                    if (count_up)
                    begin
                        if (count_reg < qcd_pkg::CountMax)
                            count_next = count_reg + 8'sd1;
                    end
                    else
                    begin
                        if (count_reg > qcd_pkg::CountMin)
                            count_next = count_reg - 8'sd1;
                    end
                end
                else
                begin
                    change_next = change_inc;
                end
            end
            else
            begin
                qual_next = qual_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pins_reg   <= qcd_pkg::PinsIdle;
            qual_reg   <= '0;
            change_reg <= '0;
            count_reg  <= '0;
        end
        else if (advance)
        begin
            pins_reg   <= pins_next;
            qual_reg   <= qual_next;
            change_reg <= change_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/qcd_display.sv @@
// Digit multiplexer: alternates tens and units of |count| onto the segments.
module qcd_display (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  logic signed [qcd_pkg::CountWidth-1:0] count,
    input  qcd_pkg::cfg_t                         cfg,
    output logic [qcd_pkg::SegWidth-1:0]          segment_reg,
    output logic [qcd_pkg::EnWidth-1:0]           enable_reg
);

    logic [qcd_pkg::MuxWidth-1:0]   mux_reg, mux_next;
    logic                           units_reg, units_next;
    logic [qcd_pkg::SegWidth-1:0]   segment_next;
    logic [qcd_pkg::EnWidth-1:0]    enable_next;
    logic [qcd_pkg::CountWidth-1:0] abs_count;
    logic [qcd_pkg::MagWidth-1:0]   mag;
    logic [qcd_pkg::DigitWidth-1:0] digit;

    assign abs_count = count[qcd_pkg::CountWidth-1] ? -count : count;
    assign mag       = abs_count[qcd_pkg::MagWidth-1:0];

    always_comb
    begin
        units_next   = units_reg;
        segment_next = segment_reg;
        enable_next  = enable_reg;
        mux_next     = mux_reg + 1'b1;
        digit        = qcd_pkg::units_of(mag);
        if (mux_reg == cfg.mux_period)
        begin
            units_next = ~units_reg;
            mux_next   = qcd_pkg::MuxWidth'(1);
            if (units_next)
            begin
                digit       = qcd_pkg::units_of(mag);
                enable_next = qcd_pkg::EnUnits;
            end
            else
            begin
                digit       = qcd_pkg::tens_of(mag);
                enable_next = qcd_pkg::EnTens;
            end
            segment_next = ~qcd_pkg::DigitFont[digit];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mux_reg     <= '0;
            units_reg   <= 1'b1;
            segment_reg <= qcd_pkg::SegBlank;
            enable_reg  <= qcd_pkg::EnNone;
        end
        else if (advance)
        begin
            mux_reg     <= mux_next;
            units_reg   <= units_next;
            segment_reg <= segment_next;
            enable_reg  <= enable_next;
        end
    end

endmodule

@@ hdl/quadrature_counter_display.sv @@
// Top level of the quadrature counter with two-digit multiplexed display.
// Each input beat is one tick carrying a sample of the two encoder pins; each
// tick yields exactly one output beat with the count, the active-low segment
// pattern and the digit enable as they stand after that tick. One beat is
// taken per clock while the output is not stalled: a sample is held in the
// input register, then the encoder and display state update when the result
// slot is free, and those state registers are the result register. Write
// configuration only while no beat is in flight.
module quadrature_counter_display (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] pin_a, [1] pin_b, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] count_value, [14:8] segments_n,
                                   // [16:15] digit_enable, rest zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    qcd_pkg::cfg_t cfg_reg;

    logic       in_valid_reg;
    logic [1:0] sample_reg;
    logic       out_valid_reg;
    logic       advance;

    logic signed [qcd_pkg::CountWidth-1:0] count_next;
    logic signed [qcd_pkg::CountWidth-1:0] count_reg;
    logic [qcd_pkg::SegWidth-1:0]          segment_reg;
    logic [qcd_pkg::EnWidth-1:0]           enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qualify_count    <= qcd_pkg::QualifyReset;
            cfg_reg.changes_per_step <= qcd_pkg::ChangeReset;
            cfg_reg.mux_period       <= qcd_pkg::MuxReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qcd_pkg::RegQualifyCount:   cfg_reg.qualify_count    <= cfg_data;
                qcd_pkg::RegChangesPerStep: cfg_reg.changes_per_step <= cfg_data[3:0];
                qcd_pkg::RegMuxPeriod:      cfg_reg.mux_period       <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Move the held sample into the state when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sample_reg <= s_tdata[1:0];
    end

    qcd_encoder u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .sample     (sample_reg),
        .cfg        (cfg_reg),
        .count_next (count_next),
        .count_reg  (count_reg)
    );

    qcd_display u_display (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .count       (count_next),
        .cfg         (cfg_reg),
        .segment_reg (segment_reg),
        .enable_reg  (enable_reg)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, enable_reg, segment_reg, count_reg};

endmodule

@@ sim/quadrature_counter_display_test.sv @@
// Self-checking testbench for the quadrature counter with multiplexed display.
module quadrature_counter_display_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] count_value;
        logic [6:0] segments_n;
        logic [1:0] digit_enable;
    } readout_t;

    // Active-high digit patterns, bit0 segment a .. bit6 segment g
    localparam logic [6:0] FontLit [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
    };

    // Pin states in clockwise order, {pin_b, pin_a}; walking forward counts up
    localparam logic [1:0] GrayWalk [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'd0;

    quadrature_counter_display dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Encoder and display state as predicted
    logic [7:0] qual_limit  = qcd_pkg::QualifyReset;
    logic [3:0] steps_limit = qcd_pkg::ChangeReset;
    logic [7:0] mux_limit   = qcd_pkg::MuxReset;
    logic [1:0] held_pins   = qcd_pkg::PinsIdle;
    logic [7:0] qual_cnt    = 8'd0;
    logic [3:0] change_cnt  = 4'd0;
    int         count_now   = 0;
    logic [7:0] mux_cnt     = 8'd0;
    logic       show_units  = 1'b1;
    logic [6:0] seg_now     = qcd_pkg::SegBlank;
    logic [1:0] en_now      = qcd_pkg::EnNone;

    logic [1:0] pin_samples [$];
    readout_t   expected_readouts [$];

    int  feed_gap = 0;
    int  stall_left = 0;
    bit  hold_taken = 1'b0;
    bit  quiet_tail = 1'b0;
    int  rot_pos = 0;
    int  samples_taken = 0;
    int  readouts_seen = 0;
    int  count_steps = 0;
    int  sat_hits = 0;
    int  errors = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Advance the encoder and display by one sample and record the readout
    task automatic predict_tick(input logic [1:0] sample);
        int       mag;
        int       digit;
        readout_t r;
        if (sample != held_pins)
        begin
            if (qual_cnt == qual_limit)
            begin
                change_cnt = change_cnt + 4'd1;
                if (change_cnt == steps_limit)
                begin
                    count_steps++;
                    if (sample[0] == held_pins[1])
                    begin
                        if (count_now < 99)
                            count_now++;
                        else
                            sat_hits++;
                    end
                    else
                    begin
                        if (count_now > -99)
                            count_now--;
                        else
                            sat_hits++;
                    end
                    change_cnt = 4'd0;
                end
                held_pins = sample;
                qual_cnt = 8'd0;
            end
            else
            begin
                qual_cnt = qual_cnt + 8'd1;
            end
        end
        if (mux_cnt == mux_limit)
        begin
            mag = (count_now < 0) ? -count_now : count_now;
            show_units = ~show_units;
            if (show_units)
            begin
                digit = mag % 10;
                en_now = qcd_pkg::EnUnits;
            end
            else
            begin
                digit = mag / 10;
                en_now = qcd_pkg::EnTens;
            end
            seg_now = ~FontLit[digit];
            mux_cnt = 8'd0;
        end
        mux_cnt = mux_cnt + 8'd1;
        r.count_value  = 8'(count_now);
        r.segments_n   = seg_now;
        r.digit_enable = en_now;
        expected_readouts.push_back(r);
    endtask

    task automatic check_readout(input logic [23:0] beat);
        readout_t r;
        readouts_seen++;
        if (expected_readouts.size() == 0)
        begin
            $error("unexpected readout beat %h", beat);
            errors++;
            return;
        end
        r = expected_readouts.pop_front();
        if (beat[7:0] !== r.count_value)
        begin
            $error("count_value: expected %0d, got %0d",
                   $signed(r.count_value), $signed(beat[7:0]));
            errors++;
        end
        if (beat[14:8] !== r.segments_n)
        begin
            $error("segments_n: expected %h, got %h", r.segments_n, beat[14:8]);
            errors++;
        end
        if (beat[16:15] !== r.digit_enable)
        begin
            $error("digit_enable: expected %0d, got %0d", r.digit_enable, beat[16:15]);
            errors++;
        end
    endtask

    // Sample feed: hold a beat until taken, insert random gaps between beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_tick(s_tdata[1:0]);
                samples_taken++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the current beat
            end
            else if (feed_gap > 0)
            begin
                s_tvalid <= 1'b0;
                feed_gap <= feed_gap - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                s_tvalid <= 1'b0;
                feed_gap <= $urandom_range(0, 3);
            end
            else if (pin_samples.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {6'd0, pin_samples.pop_front()};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Readout side: check each beat, stall at random, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_readout(m_tdata);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!hold_taken && readouts_seen >= 200)
            begin
                m_tready <= 1'b0;
                hold_taken <= 1'b1;
                stall_left <= 120;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            qcd_pkg::RegQualifyCount:   qual_limit = val;
            qcd_pkg::RegChangesPerStep: steps_limit = val[3:0];
            qcd_pkg::RegMuxPeriod:      mux_limit = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pin_samples.size() != 0 || s_tvalid || expected_readouts.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Walk the encoder n samples in one direction, holding each state a while
    task automatic queue_rotation(input int n, input bit up, input int hold_lo,
                                  input int hold_hi, input int noise_pct);
        int left;
        int hold;
        left = n;
        while (left > 0)
        begin
            rot_pos = up ? (rot_pos + 1) % 4 : (rot_pos + 3) % 4;
            hold = $urandom_range(hold_hi, hold_lo);
            for (int k = 0; k < hold && left > 0; k++)
            begin
                if ($urandom_range(99) < noise_pct)
                    pin_samples.push_back(2'($urandom_range(3)));
                else
                    pin_samples.push_back(GrayWalk[rot_pos]);
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle pins, a bounce, every pin state, then a held change
        pin_samples.push_back(2'b11);
        pin_samples.push_back(2'b11);
        pin_samples.push_back(2'b00);
        pin_samples.push_back(2'b10);
        pin_samples.push_back(2'b11);
        pin_samples.push_back(2'b01);
        for (int k = 0; k < 18; k++)
            pin_samples.push_back(2'b01);
        queue_rotation(130, 1'b1, 14, 22, 5);
        queue_rotation(130, 1'b0, 14, 22, 5);
        wait_idle();

        // Fastest settings: every change steps, drive the count into both limits
        write_reg(qcd_pkg::RegQualifyCount, 8'd0);
        write_reg(qcd_pkg::RegChangesPerStep, 8'd1);
        write_reg(qcd_pkg::RegMuxPeriod, 8'd1);
        queue_rotation(190, 1'b1, 1, 1, 0);
        queue_rotation(230, 1'b0, 1, 1, 0);
        queue_rotation(40, 1'b1, 1, 3, 15);
        wait_idle();

        // Slowest settings
        write_reg(qcd_pkg::RegQualifyCount, 8'd255);
        write_reg(qcd_pkg::RegChangesPerStep, 8'd15);
        write_reg(qcd_pkg::RegMuxPeriod, 8'd255);
        queue_rotation(280, 1'b1, 257, 260, 0);
        wait_idle();

        // Zero step divisor and zero mux period both wrap their counters
        write_reg(qcd_pkg::RegQualifyCount, 8'd3);
        write_reg(qcd_pkg::RegChangesPerStep, 8'd0);
        write_reg(qcd_pkg::RegMuxPeriod, 8'd0);
        queue_rotation(110, 1'b0, 3, 6, 10);
        queue_rotation(110, 1'b1, 3, 6, 10);
        wait_idle();

        write_reg(qcd_pkg::RegQualifyCount, 8'd1);
        write_reg(qcd_pkg::RegChangesPerStep, 8'd2);
        write_reg(qcd_pkg::RegMuxPeriod, 8'd7);
        quiet_tail = 1'b1;
        queue_rotation(120, 1'($urandom_range(1)), 2, 3, 5);
        wait_idle();

        $display("covered %0d pin samples and %0d readouts: %0d count steps, %0d at a limit",
                 samples_taken, readouts_seen, count_steps, sat_hits);
        if (errors == 0)
            $display("quadrature_counter_display_test: clean");
        else
            $display("quadrature_counter_display_test: errors");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("quadrature_counter_display_test: errors");
        $finish;
    end

endmodule
